[rtl/ffrwl_pkg.sv]
package ffrwl_pkg;

   localparam int QUEUE_DEPTH   = 16;
   localparam int ID_BITS       = 8;
   localparam int ID_FIELD_BITS = 8;
   localparam int CMD_BITS      = 2;
   localparam int READERS_BITS  = 9;
   localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [READERS_BITS-1:0]  READERS_MAX = '1;
   localparam logic [ID_FIELD_BITS-1:0] ID_MASK =
      (ID_BITS >= ID_FIELD_BITS) ? '1 : ID_FIELD_BITS'((1 << ID_BITS) - 1);
   localparam logic [CNT_BITS-1:0] QUEUE_FULL = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_START_READ  = 2'd0,
      CMD_START_WRITE = 2'd1,
      CMD_END_READ    = 2'd2,
      CMD_END_WRITE   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   typedef struct packed {
      logic                     is_writer;
      logic [ID_FIELD_BITS-1:0] id;
   } entry_type;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] ptr);
      logic [PTR_BITS-1:0] result;
      if (ptr == PTR_LAST) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

endpackage

[rtl/fifo_fair_reader_writer_lock.sv]
// flow: a request word is taken in ST_IDLE; each head check costs one read of the wait queue
//    memory in ST_READ, and ST_CHECK decides on its registered data, granting the head while
//    it can enter and going back to ST_READ; ST_FLUSH sends the last result word. A new request
//    is taken only back in ST_IDLE, and result words wait while the output is stalled
// reset: synchronous, active high; clears lock state, queue pointers and output valid,
//    the wait queue memory is not cleared
module fifo_fair_reader_writer_lock (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ffrwl_pkg::ID_FIELD_BITS-1:0]  req_tdata,  // requester_id
   input  logic [ffrwl_pkg::CMD_BITS-1:0]       req_tuser,  // cmd
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ffrwl_pkg::ID_FIELD_BITS-1:0]  rsp_tdata,  // granted_id
   output logic                                 rsp_tuser,  // overflow
   output logic                                 rsp_tlast
);
   import ffrwl_pkg::*;

   state_type                state_ff, state_in;
   logic [READERS_BITS-1:0]  readers_ff, readers_in;
   logic                     writer_ff, writer_in;
   logic [PTR_BITS-1:0]      head_ff, head_in;
   logic [PTR_BITS-1:0]      tail_ff, tail_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic                     hold_valid_ff, hold_valid_in;
   logic [ID_FIELD_BITS-1:0] hold_id_ff, hold_id_in;
   logic                     hold_ovf_ff, hold_ovf_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ID_FIELD_BITS-1:0] rsp_id_ff, rsp_id_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic                     rsp_last_ff, rsp_last_in;
   entry_type                rd_data_ff;

   entry_type                queue_mem [QUEUE_DEPTH];

   logic                     accept;
   logic                     slot_free;
   logic                     waiting;
   logic                     can_enter;
   logic                     enqueue;
   logic                     mem_we;
   entry_type                wr_entry;
   logic [ID_FIELD_BITS-1:0] req_id;
   logic [READERS_BITS-1:0]  readers_inc;
   cmd_type                  cmd;

   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign waiting     = (count_ff != '0);
   assign req_id      = req_tdata & ID_MASK;
   assign cmd         = cmd_type'(req_tuser);
   assign readers_inc = (readers_ff == READERS_MAX) ? readers_ff : readers_ff + 1'b1;
   assign can_enter   = rd_data_ff.is_writer ? (!writer_ff && readers_ff == '0) : !writer_ff;

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_id_ff;
   assign rsp_tuser   = rsp_ovf_ff;
   assign rsp_tlast   = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      readers_in    = readers_ff;
      writer_in     = writer_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      hold_ovf_in   = hold_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_id_in     = rsp_id_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      enqueue       = 1'b0;
      mem_we        = 1'b0;
      wr_entry.id        = req_id;
      wr_entry.is_writer = (cmd == CMD_START_WRITE);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_START_READ: begin
                     if (!writer_ff && !waiting) begin
                        readers_in    = readers_inc;
                        hold_valid_in = 1'b1;
                     end else begin
                        enqueue = 1'b1;
                     end
                  end
                  CMD_START_WRITE: begin
                     if (!writer_ff && readers_ff == '0 && !waiting) begin
                        writer_in     = 1'b1;
                        hold_valid_in = 1'b1;
                     end else begin
                        enqueue = 1'b1;
                     end
                  end
                  CMD_END_READ: begin
                     if (readers_ff != '0) begin
                        readers_in = readers_ff - 1'b1;
                     end
                     hold_valid_in = 1'b1;
                  end
                  CMD_END_WRITE: begin
                     writer_in     = 1'b0;
                     hold_valid_in = 1'b1;
                  end
                  default: begin
                     hold_valid_in = 1'b1;
                  end
               endcase
               hold_id_in  = req_id;
               hold_ovf_in = 1'b0;
               if (enqueue) begin
                  if (count_ff == QUEUE_FULL) begin
                     hold_valid_in = 1'b1;
                     hold_ovf_in   = 1'b1;
                  end else begin
                     mem_we   = 1'b1;
                     tail_in  = ptr_next(tail_ff);
                     count_in = count_ff + 1'b1;
                  end
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = waiting ? ST_CHECK : ST_FLUSH;
         end
         ST_CHECK: begin
            if (!can_enter) begin
               state_in = ST_FLUSH;
            end else if (!hold_valid_ff || slot_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = hold_id_ff;
                  rsp_ovf_in   = hold_ovf_ff;
                  rsp_last_in  = 1'b0;
               end
               if (rd_data_ff.is_writer) begin
                  writer_in = 1'b1;
               end else begin
                  readers_in = readers_inc;
               end
               head_in       = ptr_next(head_ff);
               count_in      = count_ff - 1'b1;
               hold_valid_in = 1'b1;
               hold_id_in    = rd_data_ff.id;
               hold_ovf_in   = 1'b0;
               state_in      = ST_READ;
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = hold_id_ff;
               rsp_ovf_in    = hold_ovf_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         readers_ff    <= '0;
         writer_ff     <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         readers_ff    <= readers_in;
         writer_ff     <= writer_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_id_ff  <= hold_id_in;
      hold_ovf_ff <= hold_ovf_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   // wait queue, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[tail_ff] <= wr_entry;
      end
      rd_data_ff <= queue_mem[head_ff];
   end

endmodule

[rtl/ffrwl_checker.sv]
module ffrwl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [ffrwl_pkg::ID_FIELD_BITS-1:0] req_tdata,  // requester_id
   input logic [ffrwl_pkg::CMD_BITS-1:0]      req_tuser,  // cmd
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ffrwl_pkg::ID_FIELD_BITS-1:0] rsp_tdata,  // granted_id
   input logic                                rsp_tuser,  // overflow
   input logic                                rsp_tlast
);
   import ffrwl_pkg::*;

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
   else $error("result word changed while stalled");

   // an overflow answer is the only word of its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
   else $error("overflow word not marked last");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
   else $error("request taken while previous one in progress");

   // nothing shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
   else $error("result valid after reset");

endmodule

bind fifo_fair_reader_writer_lock ffrwl_checker u_ffrwl_checker (.*);

[tb/fifo_fair_reader_writer_lock_tb.sv]
`timescale 1ns / 100ps

module fifo_fair_reader_writer_lock_tb;
   import ffrwl_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int MAX_PRINTS  = 50;

   typedef struct packed {
      cmd_type                  cmd;
      logic [ID_FIELD_BITS-1:0] id;
   } lock_request_type;

   typedef struct packed {
      logic [ID_FIELD_BITS-1:0] id;
      logic                     overflow;
      logic                     last;
   } grant_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ID_FIELD_BITS-1:0] req_tdata = '0;
   logic [CMD_BITS-1:0]      req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [ID_FIELD_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;

   lock_request_type requests_to_send[$];
   lock_request_type open_claims[$];
   grant_word_type   grants_due[$];

   // lock state as predicted
   logic [READERS_BITS-1:0]  readers_held;
   logic                     writer_held;
   logic [ID_FIELD_BITS-1:0] waiter_id [QUEUE_DEPTH];
   logic                     waiter_writes [QUEUE_DEPTH];
   int unsigned              wait_head;
   int unsigned              wait_tail;
   int unsigned              wait_count;

   int  mismatch_count = 0;
   int  total_pushed = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   bit  hold_done = 1'b0;

   fifo_fair_reader_writer_lock i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   function automatic void predict_lock_grants(input cmd_type cmd,
                                               input logic [ID_FIELD_BITS-1:0] raw_id);
      logic [ID_FIELD_BITS-1:0] id;
      logic                     queue_it;
      grant_word_type           words[$];
      grant_word_type           w;
      id = raw_id & ID_MASK;
      queue_it = 1'b0;
      case (cmd)
         CMD_START_READ: begin
            if (!writer_held && wait_count == 0) begin
               if (readers_held != READERS_MAX) readers_held++;
               words.push_back('{id, 1'b0, 1'b0});
            end else begin
               queue_it = 1'b1;
            end
         end
         CMD_START_WRITE: begin
            if (!writer_held && readers_held == 0 && wait_count == 0) begin
               writer_held = 1'b1;
               words.push_back('{id, 1'b0, 1'b0});
            end else begin
               queue_it = 1'b1;
            end
         end
         CMD_END_READ: begin
            if (readers_held != 0) readers_held--;
            words.push_back('{id, 1'b0, 1'b0});
         end
         default: begin
            writer_held = 1'b0;
            words.push_back('{id, 1'b0, 1'b0});
         end
      endcase
      if (queue_it) begin
         if (wait_count >= QUEUE_DEPTH) begin
            words.push_back('{id, 1'b1, 1'b0});
         end else begin
            waiter_id[wait_tail] = id;
            waiter_writes[wait_tail] = (cmd == CMD_START_WRITE);
            wait_tail = (wait_tail + 1) % QUEUE_DEPTH;
            wait_count++;
         end
      end
      // wake the head of the line while it can enter
      while (wait_count > 0) begin
         if (waiter_writes[wait_head]) begin
            if (writer_held || readers_held != 0) break;
            writer_held = 1'b1;
         end else begin
            if (writer_held) break;
            if (readers_held != READERS_MAX) readers_held++;
         end
         words.push_back('{waiter_id[wait_head], 1'b0, 1'b0});
         wait_head = (wait_head + 1) % QUEUE_DEPTH;
         wait_count--;
      end
      if (words.size() != 0) begin
         w = words.pop_back();
         w.last = 1'b1;
         words.push_back(w);
      end
      foreach (words[i]) grants_due.push_back(words[i]);
   endfunction

   task automatic push_request(input cmd_type cmd, input logic [ID_FIELD_BITS-1:0] id);
      requests_to_send.push_back('{cmd, id});
      total_pushed++;
   endtask

   task automatic start_claim(input bit is_write, input logic [ID_FIELD_BITS-1:0] id);
      cmd_type cmd;
      if (is_write) begin
         cmd = CMD_START_WRITE;
      end else begin
         cmd = CMD_START_READ;
      end
      push_request(cmd, id);
      open_claims.push_back('{cmd, id});
   endtask

   task automatic release_claim();
      int               k;
      lock_request_type c;
      cmd_type          cmd;
      k = $urandom_range(0, open_claims.size() - 1);
      c = open_claims[k];
      open_claims.delete(k);
      if (c.cmd == CMD_START_WRITE) begin
         cmd = CMD_END_WRITE;
      end else begin
         cmd = CMD_END_READ;
      end
      push_request(cmd, c.id);
   endtask

   task automatic add_lock_session();
      int                       kind;
      int                       n;
      logic [ID_FIELD_BITS-1:0] owner;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         // unmatched requests
         n = $urandom_range(1, 4);
         repeat (n) push_request(cmd_type'($urandom_range(0, 3)), ID_FIELD_BITS'($urandom));
      end else if (kind < 5) begin
         // a writer holds the lock while a crowd lines up
         owner = ID_FIELD_BITS'($urandom);
         push_request(CMD_START_WRITE, owner);
         n = $urandom_range(4, 18);
         repeat (n) start_claim($urandom_range(0, 3) == 0, ID_FIELD_BITS'($urandom));
         push_request(CMD_END_WRITE, owner);
         n = $urandom_range(0, open_claims.size());
         repeat (n) release_claim();
      end else begin
         n = $urandom_range(4, 12);
         repeat (n) begin
            if (open_claims.size() != 0 &&
                (open_claims.size() > 20 || $urandom_range(0, 1) == 0)) begin
               release_claim();
            end else begin
               start_claim($urandom_range(0, 2) == 0, ID_FIELD_BITS'($urandom));
            end
         end
      end
   endtask

   always @(posedge clock) begin : request_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_tvalid && req_tready) void'(requests_to_send.pop_front());
         if (req_tvalid && !req_tready) begin
            offer = 1'b1;
         end else if (req_gap != 0) begin
            req_gap--;
            offer = 1'b0;
         end else if (!calm && requests_to_send.size() != 0 && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 2);
            offer = 1'b0;
         end else begin
            offer = (requests_to_send.size() != 0);
         end
         req_tvalid <= offer;
         if (offer) begin
            req_tdata <= requests_to_send[0].id;
            req_tuser <= requests_to_send[0].cmd;
         end
      end
   end

   always @(posedge clock) begin : grant_monitor
      grant_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         readers_held = '0;
         writer_held = 1'b0;
         wait_head = 0;
         wait_tail = 0;
         wait_count = 0;
         rsp_gap = 0;
      end else begin
         if (req_tvalid && req_tready) predict_lock_grants(cmd_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (grants_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word id %0h", rsp_tdata));
            end else begin
               want = grants_due.pop_front();
               if (rsp_tdata !== want.id)
                  report_mismatch($sformatf("granted_id %0h, want %0h", rsp_tdata, want.id));
               if (rsp_tuser !== want.overflow)
                  report_mismatch($sformatf("overflow %0b, want %0b", rsp_tuser, want.overflow));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_tlast, want.last));
            end
         end
         if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [ID_FIELD_BITS-1:0] owner;
      int                       mark;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // readers share, writers wait their turn, ends without holders
      push_request(CMD_START_READ,  8'h00);
      push_request(CMD_START_READ,  8'hFF);
      push_request(CMD_START_WRITE, 8'hA5);
      push_request(CMD_START_READ,  8'h5A);
      push_request(CMD_END_READ,    8'h00);
      push_request(CMD_END_READ,    8'hFF);
      push_request(CMD_START_READ,  8'h3C);
      push_request(CMD_START_WRITE, 8'hC3);
      push_request(CMD_END_WRITE,   8'hA5);
      push_request(CMD_END_READ,    8'h5A);
      push_request(CMD_END_READ,    8'h3C);
      push_request(CMD_END_WRITE,   8'hC3);
      push_request(CMD_END_READ,    8'h11);
      push_request(CMD_END_WRITE,   8'h22);
      push_request(CMD_START_WRITE, 8'h80);
      push_request(CMD_START_WRITE, 8'h01);
      push_request(CMD_END_WRITE,   8'h80);
      push_request(CMD_END_WRITE,   8'h01);
      push_request(CMD_START_READ,  8'h7F);
      push_request(CMD_END_READ,    8'h7F);
      while (requests_to_send.size() != 0 || grants_due.size() != 0) @(negedge clock);

      // full wait queue, then one release wakes every waiter
      owner = ID_FIELD_BITS'($urandom);
      push_request(CMD_START_WRITE, owner);
      repeat (QUEUE_DEPTH + 1) start_claim(1'b0, ID_FIELD_BITS'($urandom));
      push_request(CMD_END_WRITE, owner);
      while (open_claims.size() != 0) release_claim();
      while (requests_to_send.size() != 0 || grants_due.size() != 0) @(negedge clock);

      mark = total_pushed;
      while (total_pushed - mark < 150) add_lock_session();
      while (requests_to_send.size() > 100) @(negedge clock);
      hold_req = 1'b1;
      while (total_pushed - mark < 300) add_lock_session();
      while (requests_to_send.size() != 0) @(negedge clock);
      calm = 1'b1;
      while (total_pushed - mark < 390) add_lock_session();

      while (requests_to_send.size() != 0 || grants_due.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[fifo_fair_reader_writer_lock.f]
rtl/ffrwl_pkg.sv
rtl/fifo_fair_reader_writer_lock.sv
rtl/ffrwl_checker.sv
tb/fifo_fair_reader_writer_lock_tb.sv
